@@ src/jti_pkg.sv @@
// Shared types and constants of the track isolation sum block.
`default_nettype none

package jti_pkg;

   // Input command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_LOAD  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // Configuration port geometry and register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_RADIUS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_RADIUS     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STRIP_HALF_WIDTH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_TRACK_PT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ABS_D0       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ABS_DZ       = 3'd5;

   // Field widths
   localparam int ETA_W  = 14;
   localparam int PHI_W  = 13;
   localparam int Z_W    = 16;
   localparam int PT_W   = 16;
   localparam int D0_W   = 16;
   localparam int SUM_W  = 24;
   localparam int RAD_W  = 13;
   localparam int RSQ_W  = 2 * RAD_W;
   localparam int KIN_W  = PT_W + ETA_W + PHI_W;
   localparam int VTX_W  = D0_W + Z_W;

   // Azimuth wrap constants in 1/1024 rad
   localparam logic signed [14:0] PHI_PI     = 15'sd3217;
   localparam logic signed [14:0] PHI_TWO_PI = 15'sd6434;

   localparam logic [SUM_W-1:0] SUM_MAX = 24'hFFFFFF;

   // Cut settings as seen by the track evaluator
   typedef struct packed {
      logic [RSQ_W-1:0] outer_sq;
      logic [RSQ_W-1:0] inner_sq;
      logic [RAD_W-1:0] strip;
      logic [15:0]      min_pt;
      logic [14:0]      max_d0;
      logic [15:0]      max_dz;
   } cfg_type;

   // Query sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ src/jti_req_if.sv @@
// Input item channel: command plus track or electron fields.
`default_nettype none

interface jti_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       cmd;
   logic signed [jti_pkg::ETA_W-1:0] eta;
   logic signed [jti_pkg::PHI_W-1:0] phi;
   logic signed [jti_pkg::Z_W-1:0]   z_zero;
   logic [jti_pkg::PT_W-1:0]         pt;
   logic signed [jti_pkg::D0_W-1:0]  d_zero;

   modport source (output valid, cmd, eta, phi, z_zero, pt, d_zero, input ready);
   modport sink   (input valid, cmd, eta, phi, z_zero, pt, d_zero, output ready);
endinterface

`default_nettype wire

@@ src/jti_rsp_if.sv @@
// Result item channel: isolation sum.
`default_nettype none

interface jti_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [jti_pkg::SUM_W-1:0] iso_sum;

   modport source (output valid, iso_sum, input ready);
   modport sink   (input valid, iso_sum, output ready);
endinterface

`default_nettype wire

@@ src/jti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module jti_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]    wr_data,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output logic      [WIDTH-1:0]    rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

`default_nettype wire

@@ src/jti_csr.sv @@
// Configuration registers and squared cone radii.
`default_nettype none

module jti_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [jti_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [jti_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output jti_pkg::cfg_type                         cfg
);
   logic [jti_pkg::RAD_W-1:0] outer_ff, outer_in;
   logic [jti_pkg::RAD_W-1:0] inner_ff, inner_in;
   logic [jti_pkg::RAD_W-1:0] strip_ff, strip_in;
   logic [15:0]               min_pt_ff, min_pt_in;
   logic [14:0]               max_d0_ff, max_d0_in;
   logic [15:0]               max_dz_ff, max_dz_in;
   logic [jti_pkg::RSQ_W-1:0] outer_sq_ff, outer_sq_in;
   logic [jti_pkg::RSQ_W-1:0] inner_sq_ff, inner_sq_in;

   // Decode register writes
   always_comb begin
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      strip_in  = strip_ff;
      min_pt_in = min_pt_ff;
      max_d0_in = max_d0_ff;
      max_dz_in = max_dz_ff;
      if (csr_we) begin
         unique case (csr_index)
            jti_pkg::CSR_OUTER_RADIUS:     outer_in  = csr_wdata[jti_pkg::RAD_W-1:0];
            jti_pkg::CSR_INNER_RADIUS:     inner_in  = csr_wdata[jti_pkg::RAD_W-1:0];
            jti_pkg::CSR_STRIP_HALF_WIDTH: strip_in  = csr_wdata[jti_pkg::RAD_W-1:0];
            jti_pkg::CSR_MIN_TRACK_PT:     min_pt_in = csr_wdata[15:0];
            jti_pkg::CSR_MAX_ABS_D0:       max_d0_in = csr_wdata[14:0];
            jti_pkg::CSR_MAX_ABS_DZ:       max_dz_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Square the radii so the evaluator compares against dR^2 directly
   assign outer_sq_in = jti_pkg::RSQ_W'(outer_ff) * jti_pkg::RSQ_W'(outer_ff);
   assign inner_sq_in = jti_pkg::RSQ_W'(inner_ff) * jti_pkg::RSQ_W'(inner_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_ff  <= 13'd409;
         inner_ff  <= 13'd15;
         strip_ff  <= 13'd15;
         min_pt_ff <= 16'd4;
         max_d0_ff <= 15'd32767;
         max_dz_ff <= 16'd65535;
      end else begin
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
         strip_ff  <= strip_in;
         min_pt_ff <= min_pt_in;
         max_d0_ff <= max_d0_in;
         max_dz_ff <= max_dz_in;
      end
   end

   always_ff @(posedge clock) begin
      outer_sq_ff <= outer_sq_in;
      inner_sq_ff <= inner_sq_in;
   end

   assign cfg.outer_sq = outer_sq_ff;
   assign cfg.inner_sq = inner_sq_ff;
   assign cfg.strip    = strip_ff;
   assign cfg.min_pt   = min_pt_ff;
   assign cfg.max_d0   = max_d0_ff;
   assign cfg.max_dz   = max_dz_ff;
endmodule

`default_nettype wire

@@ src/jti_track_eval.sv @@
// Four-stage track cut pipeline with saturating pt accumulator.
`default_nettype none

module jti_track_eval (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire jti_pkg::cfg_type                   cfg,
   input  wire logic                               acc_clear,
   input  wire logic                               trk_valid,
   input  wire logic [jti_pkg::KIN_W-1:0]          trk_kin,
   input  wire logic [jti_pkg::VTX_W-1:0]          trk_vtx,
   input  wire logic signed [jti_pkg::ETA_W-1:0]   e_eta,
   input  wire logic signed [jti_pkg::PHI_W-1:0]   e_phi,
   input  wire logic signed [jti_pkg::Z_W-1:0]     e_z,
   output logic                                    busy,
   output logic [jti_pkg::SUM_W-1:0]               iso_sum
);
   // Unpack stored track
   logic [jti_pkg::PT_W-1:0]         t_pt;
   logic signed [jti_pkg::ETA_W-1:0] t_eta;
   logic signed [jti_pkg::PHI_W-1:0] t_phi;
   logic signed [jti_pkg::D0_W-1:0]  t_d0;
   logic signed [jti_pkg::Z_W-1:0]   t_z;

   assign t_pt  = trk_kin[jti_pkg::KIN_W-1 -: jti_pkg::PT_W];
   assign t_eta = trk_kin[jti_pkg::PHI_W +: jti_pkg::ETA_W];
   assign t_phi = trk_kin[jti_pkg::PHI_W-1:0];
   assign t_d0  = trk_vtx[jti_pkg::VTX_W-1 -: jti_pkg::D0_W];
   assign t_z   = trk_vtx[jti_pkg::Z_W-1:0];

   // Stage 1: differences, phi wrap, magnitudes and linear cuts
   logic signed [14:0] de_s;
   logic [14:0]        de_mag;
   logic signed [14:0] dp_w;
   logic [14:0]        dp_mag;
   logic signed [16:0] dz_s;
   logic [16:0]        dz_mag;
   logic signed [16:0] d0_s;
   logic [16:0]        d0_mag;

   logic        v1_ff, v1_in;
   logic [13:0] de_abs_ff, de_abs_in;
   logic [13:0] dp_abs_ff, dp_abs_in;
   logic        cut1_ff, cut1_in;
   logic [15:0] pt1_ff;

   always_comb begin
      de_s   = {t_eta[13], t_eta} - {e_eta[13], e_eta};
      de_mag = de_s[14] ? 15'(-de_s) : 15'(de_s);
      dp_w   = {{2{t_phi[12]}}, t_phi} - {{2{e_phi[12]}}, e_phi};
      if (dp_w > jti_pkg::PHI_PI) begin
         dp_w = dp_w - jti_pkg::PHI_TWO_PI;
      end else if (dp_w < -jti_pkg::PHI_PI) begin
         dp_w = dp_w + jti_pkg::PHI_TWO_PI;
      end
      dp_mag = dp_w[14] ? 15'(-dp_w) : 15'(dp_w);
      dz_s   = {t_z[15], t_z} - {e_z[15], e_z};
      dz_mag = dz_s[16] ? 17'(-dz_s) : 17'(dz_s);
      d0_s   = {t_d0[15], t_d0};
      d0_mag = d0_s[16] ? 17'(-d0_s) : 17'(d0_s);

      de_abs_in = de_mag[13:0];
      dp_abs_in = dp_mag[13:0];
      cut1_in   = (t_pt >= cfg.min_pt)
                  && (dz_mag <= {1'b0, cfg.max_dz})
                  && (d0_mag <= {2'b00, cfg.max_d0})
                  && (de_mag >= {2'b00, cfg.strip});
      v1_in     = trk_valid;
   end

   // Stage 2: squares
   logic        v2_ff;
   logic [27:0] de_sq_ff, de_sq_in;
   logic [27:0] dp_sq_ff, dp_sq_in;
   logic        cut2_ff;
   logic [15:0] pt2_ff;

   assign de_sq_in = 28'(de_abs_ff) * 28'(de_abs_ff);
   assign dp_sq_in = 28'(dp_abs_ff) * 28'(dp_abs_ff);

   // Stage 3: cone annulus test, gate pt
   logic        v3_ff;
   logic [28:0] dr2;
   logic [15:0] add_pt_ff, add_pt_in;

   always_comb begin
      dr2       = {1'b0, de_sq_ff} + {1'b0, dp_sq_ff};
      add_pt_in = '0;
      if (cut2_ff && (dr2 >= 29'(cfg.inner_sq)) && (dr2 <= 29'(cfg.outer_sq))) begin
         add_pt_in = pt2_ff;
      end
   end

   // Stage 4: saturating accumulate
   logic [jti_pkg::SUM_W-1:0] acc_ff, acc_in;
   logic [jti_pkg::SUM_W:0]   acc_sum;

   always_comb begin
      acc_sum = {1'b0, acc_ff} + 25'(add_pt_ff);
      acc_in  = acc_ff;
      if (acc_clear) begin
         acc_in = '0;
      end else if (v3_ff) begin
         acc_in = acc_sum[jti_pkg::SUM_W] ? jti_pkg::SUM_MAX : acc_sum[jti_pkg::SUM_W-1:0];
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      de_abs_ff <= de_abs_in;
      dp_abs_ff <= dp_abs_in;
      cut1_ff   <= cut1_in;
      pt1_ff    <= t_pt;
      de_sq_ff  <= de_sq_in;
      dp_sq_ff  <= dp_sq_in;
      cut2_ff   <= cut1_ff;
      pt2_ff    <= pt1_ff;
      add_pt_ff <= add_pt_in;
      acc_ff    <= acc_in;
   end

   assign busy    = v1_ff | v2_ff | v3_ff;
   assign iso_sum = acc_ff;
endmodule

`default_nettype wire

@@ src/jurassic_track_isolation_sum_unit.sv @@
// Top level of the track isolation sum block: sequencer, track store and result register.
//
//   channel  | dir | handshake       | payload
//   ---------+-----+-----------------+------------------------------------------
//   req_ch   | in  | valid/ready     | cmd, eta, phi, z_zero, pt, d_zero
//   rsp_ch   | out | valid/ready     | iso_sum
//   csr_*    | in  | csr_we only     | csr_index, csr_wdata
//
// Clear and load items are taken in the idle state. A query holds the input until its
// sum is in the result register, and skips the scan with an empty store: the scan reads
// one track per cycle from the track store RAMs, then the four-stage cut pipeline drains
// and the sum moves to the result register.
// Reset clears the track count and the sequencer; the store itself is not cleared.
// req_ch.ready is high only while the sequencer is idle; a pending result does not
// block clears and loads, and a finished query waits only for the result register.
`default_nettype none

module jurassic_track_isolation_sum_unit #(
   parameter int MAX_TRACKS = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   jti_req_if.sink                                req_ch,
   jti_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [jti_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [jti_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CW = $clog2(MAX_TRACKS + 1);

   jti_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic               rd_en;
   logic               rd_valid_ff;
   logic               wr_en;
   logic               acc_clear;
   logic               emit;
   logic               eval_busy;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [jti_pkg::SUM_W-1:0] rsp_sum_ff;
   logic [jti_pkg::SUM_W-1:0] acc_sum;

   logic signed [jti_pkg::ETA_W-1:0] e_eta_ff;
   logic signed [jti_pkg::PHI_W-1:0] e_phi_ff;
   logic signed [jti_pkg::Z_W-1:0]   e_z_ff;

   logic [jti_pkg::KIN_W-1:0] wr_kin, rd_kin;
   logic [jti_pkg::VTX_W-1:0] wr_vtx, rd_vtx;

   jti_pkg::cfg_type cfg;

   // Configuration registers
   jti_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Sequencer: take items in idle, scan the store on a query, drain, emit
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      acc_clear = 1'b0;
      emit      = 1'b0;
      unique case (state_ff)
         jti_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               unique case (req_ch.cmd)
                  jti_pkg::CMD_CLEAR: begin
                     count_in = '0;
                  end
                  jti_pkg::CMD_LOAD: begin
                     if (count_ff < CW'(MAX_TRACKS)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  jti_pkg::CMD_QUERY: begin
                     acc_clear = 1'b1;
                     idx_in    = '0;
                     state_in  = (count_ff == '0) ? jti_pkg::ST_DRAIN : jti_pkg::ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         jti_pkg::ST_SCAN: begin
            rd_en  = 1'b1;
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) == count_ff) begin
               state_in = jti_pkg::ST_DRAIN;
            end
         end
         jti_pkg::ST_DRAIN: begin
            if (!rd_valid_ff && !eval_busy) begin
               state_in = jti_pkg::ST_EMIT;
            end
         end
         jti_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               emit     = 1'b1;
               state_in = jti_pkg::ST_IDLE;
            end
         end
         default: state_in = jti_pkg::ST_IDLE;
      endcase
   end

   assign req_ch.ready = (state_ff == jti_pkg::ST_IDLE);

   // Result register: set on emit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jti_pkg::ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the electron for the whole scan, and the finished sum
   always_ff @(posedge clock) begin
      if (acc_clear) begin
         e_eta_ff <= req_ch.eta;
         e_phi_ff <= req_ch.phi;
         e_z_ff   <= req_ch.z_zero;
      end
      if (emit) begin
         rsp_sum_ff <= acc_sum;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.iso_sum = rsp_sum_ff;

   // Track store: kinematics and vertex words at the same address
   assign wr_kin = {req_ch.pt, req_ch.eta, req_ch.phi};
   assign wr_vtx = {req_ch.d_zero, req_ch.z_zero};

   jti_ram #(
      .WIDTH (jti_pkg::KIN_W),
      .DEPTH (MAX_TRACKS)
   ) u_kin_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_kin),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_kin)
   );

   jti_ram #(
      .WIDTH (jti_pkg::VTX_W),
      .DEPTH (MAX_TRACKS)
   ) u_vtx_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_vtx),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_vtx)
   );

   // Cut pipeline and accumulator
   jti_track_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .acc_clear (acc_clear),
      .trk_valid (rd_valid_ff),
      .trk_kin   (rd_kin),
      .trk_vtx   (rd_vtx),
      .e_eta     (e_eta_ff),
      .e_phi     (e_phi_ff),
      .e_z       (e_z_ff),
      .busy      (eval_busy),
      .iso_sum   (acc_sum)
   );
endmodule

`default_nettype wire
